// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is high.
`define KCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent check on the rising clock edge that also runs during reset.
`define KCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== hdl/kcs_pkg.sv =====
// Package with widths, constants and beat types of the Koch subdivision unit.
`timescale 1ns / 1ps
package kcs_pkg;

   // Coordinate and intermediate widths.
   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int MAG_W   = COORD_W;
   localparam int RECIP_SH = COORD_W + 1;
   localparam int Q_W     = 2 * MAG_W - RECIP_SH;
   localparam int OFF_W   = COORD_W + 2;
   localparam int SUM_W   = COORD_W + 3;
   localparam int APEX_W  = 2 * COORD_W + 1;

   // Reciprocal of three, exact for magnitudes below 2^33 with a 33-bit shift.
   localparam logic [MAG_W-1:0] INV3 = 32'hAAAA_AAAB;

   // sqrt(3)/6 in Q0.32, and the one-half weight of the apex as a shift.
   localparam logic signed [31:0] APEX_K = 32'sd1239850262;
   localparam int HALF_SH = 31;
   localparam int APEX_SH = 32;

   // Rounding addends for the apex: ties go away from zero.
   localparam logic signed [APEX_W-1:0] RND_POS = APEX_W'(64'h0000_0000_8000_0000);
   localparam logic signed [APEX_W-1:0] RND_NEG = APEX_W'(64'h0000_0000_7FFF_FFFF);

   // Point positions within one segment.
   localparam logic [1:0] PT_START      = 2'd0;
   localparam logic [1:0] PT_THIRD      = 2'd1;
   localparam logic [1:0] PT_APEX       = 2'd2;
   localparam logic [1:0] PT_TWO_THIRDS = 2'd3;

   // One segment: start point, direction and closing flag.
   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dy;
      logic                      last;
   } seg_type;

   // One segment with the offsets of its three derived points.
   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [OFF_W-1:0]   x1;
      logic signed [OFF_W-1:0]   x2;
      logic signed [OFF_W-1:0]   x3;
      logic signed [OFF_W-1:0]   y1;
      logic signed [OFF_W-1:0]   y2;
      logic signed [OFF_W-1:0]   y3;
      logic                      last;
   } ofs_type;

endpackage

// ===== hdl/kcs_seg.sv =====
// Vertex intake: keeps the first and previous vertex and forms polygon segments.
`timescale 1ns / 1ps
module kcs_seg import kcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_vert_x,
   input  logic signed [COORD_W-1:0] req_vert_y,
   input  logic                      req_vert_last,
   output logic                      seg_valid,
   input  logic                      seg_ready,
   output seg_type                   seg
);

   logic signed [COORD_W-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic                      have_first_ff, have_first_in;
   logic                      close_ff, close_in;
   logic                      seg_valid_ff, seg_valid_in;
   seg_type                   seg_ff, seg_in;
   logic                      slot_free, req_fire, close_fire, seg_load;
   logic signed [COORD_W-1:0] a_x, a_y, b_x, b_y;

   // Handshake: a closing segment blocks new vertices until it has moved on.
   assign slot_free  = !seg_valid_ff || seg_ready;
   assign req_ready  = !close_ff && slot_free;
   assign req_fire   = req_valid && req_ready;
   assign close_fire = close_ff && slot_free;
   assign seg_load   = close_fire || (req_fire && (have_first_ff || req_vert_last));

   // Segment endpoints and direction.
   always_comb begin
      seg_in = '0;
      if (close_ff) begin
         a_x = prev_x_ff;
         a_y = prev_y_ff;
         b_x = first_x_ff;
         b_y = first_y_ff;
         seg_in.last = 1'b1;
      end else if (have_first_ff) begin
         a_x = prev_x_ff;
         a_y = prev_y_ff;
         b_x = req_vert_x;
         b_y = req_vert_y;
         seg_in.last = 1'b0;
      end else begin
         a_x = req_vert_x;
         a_y = req_vert_y;
         b_x = req_vert_x;
         b_y = req_vert_y;
         seg_in.last = 1'b1;
      end
      seg_in.ax = a_x;
      seg_in.ay = a_y;
      seg_in.dx = DIFF_W'(b_x) - DIFF_W'(a_x);
      seg_in.dy = DIFF_W'(b_y) - DIFF_W'(a_y);
   end

   // Polygon state.
   always_comb begin
      have_first_in = have_first_ff;
      close_in      = close_ff;
      if (close_fire) begin
         close_in = 1'b0;
      end
      if (req_fire) begin
         have_first_in = !req_vert_last;
         close_in      = have_first_ff && req_vert_last;
      end
      if (seg_load) begin
         seg_valid_in = 1'b1;
      end else if (seg_ready) begin
         seg_valid_in = 1'b0;
      end else begin
         seg_valid_in = seg_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff <= 1'b0;
         close_ff      <= 1'b0;
         seg_valid_ff  <= 1'b0;
      end else begin
         have_first_ff <= have_first_in;
         close_ff      <= close_in;
         seg_valid_ff  <= seg_valid_in;
      end
   end

   // Vertex and segment registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         prev_x_ff <= req_vert_x;
         prev_y_ff <= req_vert_y;
         if (!have_first_ff) begin
            first_x_ff <= req_vert_x;
            first_y_ff <= req_vert_y;
         end
      end
      if (seg_load) begin
         seg_ff <= seg_in;
      end
   end

   assign seg_valid = seg_valid_ff;
   assign seg       = seg_ff;

endmodule

// ===== hdl/kcs_arith.sv =====
// Two-stage datapath that turns a segment into the offsets of its derived points.
`timescale 1ns / 1ps
module kcs_arith import kcs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  seg_type in_seg,
   output logic    out_valid,
   input  logic    out_ready,
   output ofs_type out_ofs
);

   // Products of the first stage.
   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dy;
      logic                      sx;
      logic                      sy;
      logic [Q_W-1:0]            qx;
      logic [Q_W-1:0]            qy;
      logic [1:0]                mlx;
      logic [1:0]                mly;
      logic signed [APEX_W-1:0]  kx;
      logic signed [APEX_W-1:0]  ky;
      logic                      last;
   } mul_type;

   logic                      mv_ff, mv_in, ov_ff, ov_in;
   mul_type                   mul_ff, mul_in;
   ofs_type                   ofs_ff, ofs_in;
   logic                      in_fire, m_adv;
   logic [DIFF_W-1:0]         neg_x, neg_y;
   logic [MAG_W-1:0]          mag_x, mag_y;
   logic [2*MAG_W-1:0]        prod_x, prod_y;
   logic [1:0]                q3_x, q3_y, r_x, r_y;
   logic [MAG_W-1:0]          m1_x, m1_y, m3_x, m3_y;
   logic [OFF_W-1:0]          e1_x, e1_y, e3_x, e3_y;
   logic signed [APEX_W-1:0]  sum_x, sum_y, rnd_x, rnd_y;

   // Stage handshakes.
   assign m_adv    = mv_ff && (!ov_ff || out_ready);
   assign in_ready = !mv_ff || m_adv;
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      if (in_fire) begin
         mv_in = 1'b1;
      end else if (m_adv) begin
         mv_in = 1'b0;
      end else begin
         mv_in = mv_ff;
      end
      if (m_adv) begin
         ov_in = 1'b1;
      end else if (out_ready) begin
         ov_in = 1'b0;
      end else begin
         ov_in = ov_ff;
      end
   end

   // First stage: magnitudes, reciprocal products for the thirds, apex products.
   always_comb begin
      neg_x  = -in_seg.dx;
      neg_y  = -in_seg.dy;
      mag_x  = in_seg.dx[DIFF_W-1] ? neg_x[MAG_W-1:0] : in_seg.dx[MAG_W-1:0];
      mag_y  = in_seg.dy[DIFF_W-1] ? neg_y[MAG_W-1:0] : in_seg.dy[MAG_W-1:0];
      prod_x = {{MAG_W{1'b0}}, mag_x} * {{MAG_W{1'b0}}, INV3};
      prod_y = {{MAG_W{1'b0}}, mag_y} * {{MAG_W{1'b0}}, INV3};
      mul_in.ax   = in_seg.ax;
      mul_in.ay   = in_seg.ay;
      mul_in.dx   = in_seg.dx;
      mul_in.dy   = in_seg.dy;
      mul_in.sx   = in_seg.dx[DIFF_W-1];
      mul_in.sy   = in_seg.dy[DIFF_W-1];
      mul_in.qx   = prod_x[2*MAG_W-1:RECIP_SH];
      mul_in.qy   = prod_y[2*MAG_W-1:RECIP_SH];
      mul_in.mlx  = mag_x[1:0];
      mul_in.mly  = mag_y[1:0];
      mul_in.kx   = APEX_W'(in_seg.dx) * APEX_W'(APEX_K);
      mul_in.ky   = APEX_W'(in_seg.dy) * APEX_W'(APEX_K);
      mul_in.last = in_seg.last;
   end

   // Second stage: rounded thirds from quotient and remainder, rounded apex offsets.
   always_comb begin
      q3_x = mul_ff.qx[1:0] + {mul_ff.qx[0], 1'b0};
      q3_y = mul_ff.qy[1:0] + {mul_ff.qy[0], 1'b0};
      r_x  = mul_ff.mlx - q3_x;
      r_y  = mul_ff.mly - q3_y;
      m1_x = {1'b0, mul_ff.qx} + MAG_W'(r_x == 2'd2);
      m1_y = {1'b0, mul_ff.qy} + MAG_W'(r_y == 2'd2);
      m3_x = {mul_ff.qx, 1'b0} + MAG_W'(r_x != 2'd0);
      m3_y = {mul_ff.qy, 1'b0} + MAG_W'(r_y != 2'd0);
      e1_x = {{(OFF_W-MAG_W){1'b0}}, m1_x};
      e1_y = {{(OFF_W-MAG_W){1'b0}}, m1_y};
      e3_x = {{(OFF_W-MAG_W){1'b0}}, m3_x};
      e3_y = {{(OFF_W-MAG_W){1'b0}}, m3_y};

      sum_x = (APEX_W'(mul_ff.dx) <<< HALF_SH) + mul_ff.ky;
      sum_y = (APEX_W'(mul_ff.dy) <<< HALF_SH) - mul_ff.kx;
      rnd_x = sum_x + (sum_x[APEX_W-1] ? RND_NEG : RND_POS);
      rnd_y = sum_y + (sum_y[APEX_W-1] ? RND_NEG : RND_POS);

      ofs_in.ax   = mul_ff.ax;
      ofs_in.ay   = mul_ff.ay;
      ofs_in.x1   = mul_ff.sx ? -e1_x : e1_x;
      ofs_in.y1   = mul_ff.sy ? -e1_y : e1_y;
      ofs_in.x3   = mul_ff.sx ? -e3_x : e3_x;
      ofs_in.y3   = mul_ff.sy ? -e3_y : e3_y;
      ofs_in.x2   = {rnd_x[APEX_W-1], rnd_x[APEX_W-1:APEX_SH]};
      ofs_in.y2   = {rnd_y[APEX_W-1], rnd_y[APEX_W-1:APEX_SH]};
      ofs_in.last = mul_ff.last;
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         mv_ff <= mv_in;
         ov_ff <= ov_in;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (in_fire) begin
         mul_ff <= mul_in;
      end
      if (m_adv) begin
         ofs_ff <= ofs_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_ofs   = ofs_ff;

endmodule

// ===== hdl/kcs_emit.sv =====
// Point sequencer: sends the four points of each segment through the result register.
`timescale 1ns / 1ps
module kcs_emit import kcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  ofs_type                   in_ofs,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_pt_x,
   output logic signed [COORD_W-1:0] rsp_pt_y,
   output logic                      rsp_pt_last
);

   logic                      sv_ff, sv_in;
   ofs_type                   seg_ff;
   logic [1:0]                idx_ff, idx_in;
   logic                      rv_ff, rv_in;
   logic [COORD_W-1:0]        px_ff, px_in, py_ff, py_in;
   logic                      pl_ff, pl_in;
   logic                      out_free, emit, seg_done, in_fire;
   logic signed [OFF_W-1:0]   off_x, off_y;
   logic [SUM_W-1:0]          sum_x, sum_y;

   // Clamp a widened sum to the signed coordinate range.
   function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] s);
      logic top_ones, top_zeros;
      top_ones  = &s[SUM_W-1:COORD_W-1];
      top_zeros = ~|s[SUM_W-1:COORD_W-1];
      if (top_ones || top_zeros) begin
         return s[COORD_W-1:0];
      end else if (s[SUM_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   // Handshakes: one point per cycle while the result register drains.
   assign out_free = !rv_ff || rsp_ready;
   assign emit     = sv_ff && out_free;
   assign seg_done = emit && (idx_ff == PT_TWO_THIRDS);
   assign in_ready = !sv_ff || seg_done;
   assign in_fire  = in_valid && in_ready;

   // Offset of the current point.
   always_comb begin
      case (idx_ff)
         PT_START: begin
            off_x = '0;
            off_y = '0;
         end
         PT_THIRD: begin
            off_x = seg_ff.x1;
            off_y = seg_ff.y1;
         end
         PT_APEX: begin
            off_x = seg_ff.x2;
            off_y = seg_ff.y2;
         end
         PT_TWO_THIRDS: begin
            off_x = seg_ff.x3;
            off_y = seg_ff.y3;
         end
         default: begin
            off_x = '0;
            off_y = '0;
         end
      endcase
      sum_x = SUM_W'(seg_ff.ax) + SUM_W'(off_x);
      sum_y = SUM_W'(seg_ff.ay) + SUM_W'(off_y);
      px_in = sat_coord(sum_x);
      py_in = sat_coord(sum_y);
      pl_in = seg_ff.last && (idx_ff == PT_TWO_THIRDS);
   end

   // Next control state.
   always_comb begin
      if (in_fire) begin
         sv_in = 1'b1;
      end else if (seg_done) begin
         sv_in = 1'b0;
      end else begin
         sv_in = sv_ff;
      end
      if (seg_done) begin
         idx_in = PT_START;
      end else if (emit) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
      if (emit) begin
         rv_in = 1'b1;
      end else if (rsp_ready) begin
         rv_in = 1'b0;
      end else begin
         rv_in = rv_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff  <= 1'b0;
         idx_ff <= PT_START;
         rv_ff  <= 1'b0;
      end else begin
         sv_ff  <= sv_in;
         idx_ff <= idx_in;
         rv_ff  <= rv_in;
      end
   end

   // Segment and result payloads.
   always_ff @(posedge clock) begin
      if (in_fire) begin
         seg_ff <= in_ofs;
      end
      if (emit) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pl_ff <= pl_in;
      end
   end

   assign rsp_valid   = rv_ff;
   assign rsp_pt_x    = px_ff;
   assign rsp_pt_y    = py_ff;
   assign rsp_pt_last = pl_ff;

endmodule

// ===== hdl/koch_curve_subdivision_unit.sv =====
// Top level of the Koch subdivision unit: vertex intake, datapath and point sequencer.
//
//   channel | direction | beat                                   | handshake
//   req     | in        | vert_x, vert_y (Q16.16), vert_last     | req_valid / req_ready
//   rsp     | out       | pt_x, pt_y (Q16.16, saturated), pt_last| rsp_valid / rsp_ready
//
// Each segment leaves as four result beats, one per cycle while rsp_ready is high; the
// single result register sets this rate. A last vertex after the first adds two segments.
// Beats pass the segment, datapath and sequencer registers before the result register.
// Synchronous active-high reset clears all valid flags and the polygon state.
// A stall on rsp holds the result beat; the pipeline keeps filling behind it.
`timescale 1ns / 1ps
module koch_curve_subdivision_unit import kcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_vert_x,
   input  logic signed [COORD_W-1:0] req_vert_y,
   input  logic                      req_vert_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_pt_x,
   output logic signed [COORD_W-1:0] rsp_pt_y,
   output logic                      rsp_pt_last
);

   logic    seg_valid, seg_ready, ofs_valid, ofs_ready;
   seg_type seg;
   ofs_type ofs;

   // Vertex intake and segment forming.
   kcs_seg u_seg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_vert_x    (req_vert_x),
      .req_vert_y    (req_vert_y),
      .req_vert_last (req_vert_last),
      .seg_valid     (seg_valid),
      .seg_ready     (seg_ready),
      .seg           (seg)
   );

   // Offset datapath.
   kcs_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seg_valid),
      .in_ready  (seg_ready),
      .in_seg    (seg),
      .out_valid (ofs_valid),
      .out_ready (ofs_ready),
      .out_ofs   (ofs)
   );

   // Point sequencer and result register.
   kcs_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (ofs_valid),
      .in_ready    (ofs_ready),
      .in_ofs      (ofs),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_pt_x    (rsp_pt_x),
      .rsp_pt_y    (rsp_pt_y),
      .rsp_pt_last (rsp_pt_last)
   );

endmodule

// ===== hdl/kcs_checker.sv =====
// Port-level checker for the Koch subdivision unit and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kcs_checker import kcs_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic signed [COORD_W-1:0] req_vert_x,
   input logic signed [COORD_W-1:0] req_vert_y,
   input logic                      req_vert_last,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [COORD_W-1:0] rsp_pt_x,
   input logic signed [COORD_W-1:0] rsp_pt_y,
   input logic                      rsp_pt_last
);

   logic                 req_stall, rsp_stall, rsp_close, close_fire;
   logic [2*COORD_W+1:0] req_view;
   logic [2*COORD_W:0]   rsp_beat;

   // Stall, closing and payload views of both channels.
   assign req_stall  = req_valid && !req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_close  = rsp_valid && rsp_pt_last;
   assign close_fire = rsp_close && rsp_ready;
   assign req_view   = {req_valid, req_vert_x, req_vert_y, req_vert_last};
   assign rsp_beat   = {rsp_pt_x, rsp_pt_y, rsp_pt_last};

   // A stalled vertex beat stays offered with the same payload.
   `KCS_ASSERT(a_req_hold, clock, reset, req_stall |=> $stable(req_view), "req beat changed")

   // A stalled result beat stays offered.
   `KCS_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "rsp beat dropped")

   // A stalled result beat keeps its payload.
   `KCS_ASSERT(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_beat), "rsp payload changed")

   // Reset empties the result register.
   `KCS_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // The closing beat of a polygon is never directly followed by another closing beat.
   `KCS_ASSERT(a_last_gap, clock, reset, close_fire |=> !rsp_close, "closing beat repeated")

endmodule

bind koch_curve_subdivision_unit kcs_checker u_kcs_checker (.*);

// ===== sim/tb_koch_curve_subdivision_unit.sv =====
// Self-checking testbench for the Koch subdivision unit with its own point predictor.
`timescale 1ns / 1ps
module tb_koch_curve_subdivision_unit import kcs_pkg::*;;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PRINT_CAP = 40;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   // sqrt(3)/6 and one half, both scaled by 2^32.
   localparam logic signed [127:0] APEX_WEIGHT = 128'sd1239850262;
   localparam logic signed [127:0] HALF_WEIGHT = 128'sh8000_0000;
   localparam logic [127:0] Q32_DIVISOR = 128'h1_0000_0000;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_vert_x = '0;
   logic signed [COORD_W-1:0] req_vert_y = '0;
   logic req_vert_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_pt_x;
   logic signed [COORD_W-1:0] rsp_pt_y;
   logic rsp_pt_last;

   // Points still owed by the block, oldest first.
   point_type pending_points[$];

   // Polygon tracking of the predictor.
   logic signed [COORD_W-1:0] poly_start_x = '0;
   logic signed [COORD_W-1:0] poly_start_y = '0;
   logic signed [COORD_W-1:0] tail_x = '0;
   logic signed [COORD_W-1:0] tail_y = '0;
   logic poly_open = 1'b0;

   int send_idle_pct = 19;
   int recv_idle_pct = 75;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int vertices_sent = 0;

   koch_curve_subdivision_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_vert_x(req_vert_x),
      .req_vert_y(req_vert_y),
      .req_vert_last(req_vert_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pt_x(rsp_pt_x),
      .rsp_pt_y(rsp_pt_y),
      .rsp_pt_last(rsp_pt_last)
   );

   // Free-running clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Division rounded to nearest, ties away from zero.
   function automatic logic signed [127:0] round_div(input logic signed [127:0] v,
                                                     input logic [127:0] divisor);
      logic [127:0] mag;
      logic [127:0] quo;
      logic [127:0] rem;
      mag = v[127] ? -v : v;
      quo = mag / divisor;
      rem = mag % divisor;
      if (2 * rem >= divisor) quo = quo + 1;
      return v[127] ? -$signed(quo) : $signed(quo);
   endfunction

   // Saturation to the signed coordinate range.
   function automatic logic signed [COORD_W-1:0] clamp_coord(input logic signed [127:0] v);
      if (v > 128'sh7FFF_FFFF) return COORD_MAX;
      if (v < -128'sh8000_0000) return COORD_MIN;
      return v[COORD_W-1:0];
   endfunction

   // Queues the four points of the segment from a to b.
   function automatic void queue_segment_points(input logic signed [COORD_W-1:0] ax, ay, bx, by,
                                                input logic closing);
      logic signed [127:0] wax, way, dx, dy, apx, apy;
      wax = ax;
      way = ay;
      dx = bx;
      dx = dx - wax;
      dy = by;
      dy = dy - way;
      apx = dx * HALF_WEIGHT + dy * APEX_WEIGHT;
      apy = dy * HALF_WEIGHT - dx * APEX_WEIGHT;
      pending_points.push_back('{ax, ay, 1'b0});
      pending_points.push_back('{clamp_coord(wax + round_div(dx, 3)),
                                 clamp_coord(way + round_div(dy, 3)), 1'b0});
      pending_points.push_back('{clamp_coord(wax + round_div(apx, Q32_DIVISOR)),
                                 clamp_coord(way + round_div(apy, Q32_DIVISOR)), 1'b0});
      pending_points.push_back('{clamp_coord(wax + round_div(dx + dx, 3)),
                                 clamp_coord(way + round_div(dy + dy, 3)), closing});
   endfunction

   // Predicts the points caused by one accepted vertex.
   function automatic void track_vertex(input logic signed [COORD_W-1:0] x, y,
                                        input logic last);
      if (!poly_open) begin
         poly_start_x = x;
         poly_start_y = y;
         tail_x = x;
         tail_y = y;
         // A lone closing vertex makes a degenerate segment to itself.
         if (last) queue_segment_points(x, y, x, y, 1'b1);
         else poly_open = 1'b1;
      end else begin
         queue_segment_points(tail_x, tail_y, x, y, 1'b0);
         tail_x = x;
         tail_y = y;
         if (last) begin
            queue_segment_points(x, y, poly_start_x, poly_start_y, 1'b1);
            poly_open = 1'b0;
         end
      end
   endfunction

   // Random coordinate: full range, small values, or an extreme.
   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6, 7: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
         8: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
         default: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // Offers one vertex beat and waits until it is taken.
   task automatic send_vertex(input logic signed [COORD_W-1:0] x, y, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vert_x <= x;
      req_vert_y <= y;
      req_vert_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_vertex(x, y, last);
      vertices_sent++;
   endtask

   task automatic send_random_polygon();
      int len;
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(7, 2);
      for (int i = 0; i < len; i++) send_vertex(pick_coord(), pick_coord(), i == len - 1);
   endtask

   // Single closing vertices, including the coordinate extremes.
   task automatic test_lone_vertices();
      send_vertex(32'sd0, 32'sd0, 1'b1);
      send_vertex(COORD_MAX, COORD_MIN, 1'b1);
      send_vertex(COORD_MIN, COORD_MAX, 1'b1);
      send_vertex(-32'sd1, 32'sd1, 1'b1);
   endtask

   // An ordinary triangle: opening, middle and closing vertex.
   task automatic test_triangle();
      send_vertex(32'sd0, 32'sd0, 1'b0);
      send_vertex(32'sh0003_0000, 32'sd0, 1'b0);
      send_vertex(32'sh0001_8000, 32'sh0002_9000, 1'b1);
   endtask

   // Segments spanning the full range between the coordinate extremes.
   task automatic test_saturation();
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b1);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MIN, COORD_MAX, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b1);
   endtask

   // Unit steps put the apex exactly halfway, so the rounding of ties shows.
   task automatic test_rounding();
      send_vertex(32'sd0, 32'sd0, 1'b0);
      send_vertex(32'sd1, 32'sd0, 1'b0);
      send_vertex(-32'sd1, 32'sd0, 1'b1);
      send_vertex(32'sd5, 32'sd7, 1'b0);
      send_vertex(32'sd6, 32'sd9, 1'b1);
   endtask

   // Long receiver hold-off while vertices keep coming, so the input stalls.
   task automatic test_backpressure();
      int saved_send;
      saved_send = send_idle_pct;
      send_idle_pct = 0;
      hold_left <= 400;
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < 4; i++) send_vertex(pick_coord(), pick_coord(), i == 3);
      end
      send_idle_pct = saved_send;
   endtask

   task automatic test_random_polygons(input int snd_pct, input int rcv_pct, input int count);
      int goal;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      goal = vertices_sent + count;
      while (vertices_sent < goal) send_random_polygon();
   endtask

   // Receiver readiness: random idling unless a hold-off is running.
   always @(posedge clock) begin
      if (hold_left != 0) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Hold-off countdown.
   always @(posedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // Compares each accepted result beat with the oldest predicted point.
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            report_mismatch("result beat with no point expected");
         end else begin
            want = pending_points.pop_front();
            if (rsp_pt_x !== want.x)
               report_mismatch($sformatf("pt_x got %0d want %0d", rsp_pt_x, want.x));
            if (rsp_pt_y !== want.y)
               report_mismatch($sformatf("pt_y got %0d want %0d", rsp_pt_y, want.y));
            if (rsp_pt_last !== want.last)
               report_mismatch($sformatf("pt_last got %0b want %0b", rsp_pt_last, want.last));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_koch_curve_subdivision_unit: errors");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_lone_vertices();
      test_triangle();
      test_saturation();
      test_rounding();
      test_backpressure();
      test_random_polygons(19, 75, 79);
      test_random_polygons(75, 19, 79);
      test_random_polygons(0, 0, 79);
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_koch_curve_subdivision_unit: clean");
      end else begin
         $display("tb_koch_curve_subdivision_unit: errors");
      end
      $finish;
   end

endmodule
